/* rtl/tbss_pkg.sv */
`timescale 1ns / 1ps
package tbss_pkg;

	// Fixed formats
	localparam int SAMPLE_W    = 24;
	localparam int STATE_W     = 32;
	localparam int FRAC        = SAMPLE_W - 1;
	localparam int GAIN_W      = 16;
	localparam int COEF_W      = 17;
	localparam int SETTING_W   = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	// Saturator table: TANH_DEPTH+1 points over [0,4], TAB_FRAC fraction bits
	localparam int TANH_DEPTH  = 256;
	localparam int TANH_ADDR_W = $clog2(TANH_DEPTH);
	localparam int TAB_FRAC    = 31;
	localparam int TAB_W       = TAB_FRAC + 1;
	localparam int TANH_FR_W   = FRAC + 2;
	localparam int TANH_IDX_SH = TANH_FR_W - TANH_ADDR_W;
	localparam int ARG_W       = 35;

	// Sequencer steps
	localparam logic [3:0] STEP_LO   = 4'd0;
	localparam logic [3:0] STEP_HI   = 4'd1;
	localparam logic [3:0] STEP_BP   = 4'd2;
	localparam logic [3:0] STEP_FEED = 4'd2;
	localparam logic [3:0] STEP_CAP  = 4'd7;
	localparam logic [3:0] STEP_MIX  = 4'd10;
	localparam logic [3:0] STEP_LAST = 4'd11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_COEF,
		REG_DAMPING,
		REG_INPUT_GAIN,
		REG_OUTPUT_LEVEL,
		REG_LOW_SETTING,
		REG_MID_SETTING,
		REG_TOP_SETTING
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_WAIT
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic signed [SAMPLE_W-1:0] left_low;
		logic signed [SAMPLE_W-1:0] left_mid;
		logic signed [SAMPLE_W-1:0] left_top;
		logic signed [SAMPLE_W-1:0] right_low;
		logic signed [SAMPLE_W-1:0] right_mid;
		logic signed [SAMPLE_W-1:0] right_top;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0] drive;
		logic [GAIN_W-1:0] pan;
		logic [GAIN_W-1:0] level;
	} band_setting_t;

	typedef struct packed {
		logic [COEF_W-1:0]     freq_coef;
		logic [GAIN_W-1:0]     damping;
		logic [GAIN_W-1:0]     input_gain;
		logic [GAIN_W-1:0]     output_level;
		band_setting_t [2:0]   band;
	} cfg_t;

	typedef struct packed {
		logic       svf_lo;
		logic       svf_hi;
		logic       svf_bp;
		logic [1:0] band_sel;
		logic       band_cap;
		logic [1:0] cap_sel;
		logic       mix;
	} lane_ctrl_t;

	// Clamp to state width
	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sh0_7FFF_FFFF;
		lo = -hi - 36'sd1;
		if (v > hi) return hi[STATE_W-1:0];
		if (v < lo) return lo[STATE_W-1:0];
		return v[STATE_W-1:0];
	endfunction

	// Clamp to sample width
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sh00_007F_FFFF;
		lo = -hi - 40'sd1;
		if (v > hi) return hi[SAMPLE_W-1:0];
		if (v < lo) return lo[SAMPLE_W-1:0];
		return v[SAMPLE_W-1:0];
	endfunction

	typedef logic [TAB_W-1:0] tanh_tab_t [TANH_DEPTH+1];

	// tanh points from the 7/6 Pade form, monotonic, capped at 1.0
	function automatic tanh_tab_t build_tanh();
		tanh_tab_t   tab;
		logic [63:0] xq;
		logic [63:0] s;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] prev;
		logic [127:0] num;
		logic [127:0] r;
		logic [127:0] q;
		prev = '0;
		for (int i = 0; i <= TANH_DEPTH; i++) begin
			xq = (64'(i) << 18) / TANH_DEPTH;
			s = (xq * xq) >> 16;
			a = ((((s + (64'd378 << 16)) * s) >> 16) + (64'd17325 << 16)) * s;
			b = ((((64'd28 * s + (64'd3150 << 16)) * s) >> 16) + (64'd62370 << 16)) * s;
			a = (a >> 16) + (64'd135135 << 16);
			b = (b >> 16) + (64'd135135 << 16);
			num = {64'd0, xq * a} << 15;
			r = '0;
			q = '0;
			for (int k = 127; k >= 0; k--) begin
				r = {r[126:0], num[k]};
				q = q << 1;
				if (r >= {64'd0, b}) begin
					r = r - {64'd0, b};
					q[0] = 1'b1;
				end
			end
			if (q > (128'd1 << TAB_FRAC)) q = 128'd1 << TAB_FRAC;
			if (q < {64'd0, prev}) q = {64'd0, prev};
			tab[i] = q[TAB_W-1:0];
			prev = q[63:0];
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

/* rtl/tbss_lane.sv */
`timescale 1ns / 1ps
module tbss_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tbss_pkg::lane_ctrl_t                ctrl,
	input  tbss_pkg::cfg_t                      cfg,
	input  logic                                right_chan,
	input  logic signed [tbss_pkg::SAMPLE_W-1:0] sample,
	output logic signed [tbss_pkg::SAMPLE_W-1:0] low_y,
	output logic signed [tbss_pkg::SAMPLE_W-1:0] mid_y,
	output logic signed [tbss_pkg::SAMPLE_W-1:0] top_y
);
	import tbss_pkg::*;

	// Filter state
	logic signed [STATE_W-1:0] low_q;
	logic signed [STATE_W-1:0] band_q;
	logic signed [STATE_W-1:0] lo_s1;
	logic signed [32:0]        qb_s1;
	logic signed [STATE_W-1:0] hi_s2;

	logic signed [STATE_W-1:0] f_src;
	logic [31:0]               f_mag;
	logic [48:0]               fb_prod;
	logic [32:0]               fb_mag;
	logic signed [33:0]        fb_val;
	logic [31:0]               band_mag;
	logic [47:0]               qb_prod;
	logic [31:0]               qb_mag;
	logic signed [32:0]        qb_val;
	logic signed [35:0]        lo_sum;
	logic signed [35:0]        bp_sum;
	logic [SAMPLE_W-1:0]       x_mag;
	logic [39:0]               gx_prod;
	logic [27:0]               gx_mag;
	logic signed [28:0]        gx_val;
	logic signed [35:0]        hi_sum;

	// Shared coefficient multiplier: band on the low step, high on the band step
	always_comb begin
		f_src = ctrl.svf_bp ? hi_s2 : band_q;
		f_mag = f_src[STATE_W-1] ? 32'(-f_src) : 32'(f_src);
		fb_prod = 49'(cfg.freq_coef) * 49'(f_mag);
		fb_mag = 33'((fb_prod + 49'd32768) >> 16);
		fb_val = f_src[STATE_W-1] ? -$signed({1'b0, fb_mag}) : $signed({1'b0, fb_mag});
		band_mag = band_q[STATE_W-1] ? 32'(-band_q) : 32'(band_q);
		qb_prod = 48'(cfg.damping) * 48'(band_mag);
		qb_mag = 32'((qb_prod + 48'd32768) >> 16);
		qb_val = band_q[STATE_W-1] ? -$signed({1'b0, qb_mag}) : $signed({1'b0, qb_mag});
		lo_sum = 36'(low_q) + 36'(fb_val);
		bp_sum = 36'(band_q) + 36'(fb_val);
		x_mag = sample[SAMPLE_W-1] ? 24'(-sample) : 24'(sample);
		gx_prod = 40'(cfg.input_gain) * 40'(x_mag);
		gx_mag = 28'((gx_prod + 40'd2048) >> 12);
		gx_val = sample[SAMPLE_W-1] ? -$signed({1'b0, gx_mag}) : $signed({1'b0, gx_mag});
		hi_sum = 36'(gx_val) - 36'(lo_s1) - 36'(qb_s1);
	end

	always_ff @(posedge clk) begin
		if (ctrl.svf_lo) begin
			lo_s1 <= sat_state(lo_sum);
			qb_s1 <= qb_val;
		end
		if (ctrl.svf_hi) begin
			hi_s2 <= sat_state(hi_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (ctrl.svf_bp) begin
			low_q  <= lo_s1;
			band_q <= sat_state(bp_sum);
		end
	end

	// Band pipeline: one band enters per cycle
	band_setting_t             set_sel;
	logic signed [STATE_W-1:0] part_sel;
	logic [16:0]               factor;
	logic [32:0]               dr_prod;

	always_comb begin
		case (ctrl.band_sel)
			2'd0: begin
				set_sel  = cfg.band[0];
				part_sel = lo_s1;
			end
			2'd1: begin
				set_sel  = cfg.band[1];
				part_sel = band_q;
			end
			default: begin
				set_sel  = cfg.band[2];
				part_sel = hi_s2;
			end
		endcase
		factor = right_chan ? {1'b0, set_sel.pan} : 17'h10000 - 17'(set_sel.pan);
		dr_prod = 33'(set_sel.drive) * 33'(factor);
	end

	logic [GAIN_W-1:0]         drive_s1;
	logic signed [STATE_W-1:0] part_s1;
	logic [GAIN_W-1:0]         level_s1;

	always_ff @(posedge clk) begin
		drive_s1 <= 16'((dr_prod + 33'd32768) >> 16);
		part_s1  <= part_sel;
		level_s1 <= set_sel.level;
	end

	// Drive times part
	logic [31:0]       part_mag;
	logic [47:0]       arg_prod;
	logic [ARG_W-1:0]  m_s2;
	logic              neg_s2;
	logic [GAIN_W-1:0] level_s2;

	always_comb begin
		part_mag = part_s1[STATE_W-1] ? 32'(-part_s1) : 32'(part_s1);
		arg_prod = 48'(drive_s1) * 48'(part_mag);
	end

	always_ff @(posedge clk) begin
		m_s2     <= ARG_W'((arg_prod + 48'd2048) >> 12);
		neg_s2   <= part_s1[STATE_W-1];
		level_s2 <= level_s1;
	end

	// Table lookup, clipped above 4.0
	logic                   big;
	logic [TANH_ADDR_W-1:0] idx;
	logic [TANH_ADDR_W:0]   idx_next;
	logic [TAB_W-1:0]       tab_lo;
	logic [TAB_W-1:0]       tab_hi;
	logic [TAB_W-1:0]       base_s3;
	logic [TAB_W-1:0]       d_s3;
	logic [TANH_FR_W-1:0]   fr_s3;
	logic                   neg_s3;
	logic [GAIN_W-1:0]      level_s3;

	always_comb begin
		big = |m_s2[ARG_W-1:TANH_FR_W];
		idx = m_s2[TANH_FR_W-1 -: TANH_ADDR_W];
		idx_next = {1'b0, idx} + 1'b1;
		tab_lo = TANH_TAB[idx];
		tab_hi = TANH_TAB[idx_next];
	end

	always_ff @(posedge clk) begin
		base_s3  <= big ? TANH_TAB[TANH_DEPTH] : tab_lo;
		d_s3     <= big ? '0 : tab_hi - tab_lo;
		fr_s3    <= big ? '0 : {m_s2[TANH_IDX_SH-1:0], TANH_ADDR_W'(0)};
		neg_s3   <= neg_s2;
		level_s3 <= level_s2;
	end

	// Interpolate, drop to sample precision
	logic [56:0]         df_prod;
	logic [TAB_W-1:0]    t_int;
	logic [SAMPLE_W-1:0] t_rnd;
	logic signed [24:0]  t_s4;
	logic [GAIN_W-1:0]   level_s4;

	always_comb begin
		df_prod = 57'(d_s3) * 57'(fr_s3);
		t_int = base_s3 + TAB_W'(df_prod >> TANH_FR_W);
		t_rnd = SAMPLE_W'((33'(t_int) + 33'd128) >> (TAB_FRAC - FRAC));
	end

	always_ff @(posedge clk) begin
		t_s4     <= neg_s3 ? -$signed({1'b0, t_rnd}) : $signed({1'b0, t_rnd});
		level_s4 <= level_s3;
	end

	// Band level
	logic [SAMPLE_W-1:0]       t_mag;
	logic [39:0]               lv_prod;
	logic [27:0]               lv_mag;
	logic signed [28:0]        lv_val;
	logic signed [SAMPLE_W-1:0] y_s5;

	always_comb begin
		t_mag = t_s4[24] ? 24'(-t_s4) : 24'(t_s4);
		lv_prod = 40'(level_s4) * 40'(t_mag);
		lv_mag = 28'((lv_prod + 40'd2048) >> 12);
		lv_val = t_s4[24] ? -$signed({1'b0, lv_mag}) : $signed({1'b0, lv_mag});
	end

	always_ff @(posedge clk) begin
		y_s5 <= sat_sample(40'(lv_val));
	end

	// Collect band results
	always_ff @(posedge clk) begin
		if (ctrl.band_cap) begin
			case (ctrl.cap_sel)
				2'd0:    low_y <= y_s5;
				2'd1:    mid_y <= y_s5;
				default: top_y <= y_s5;
			endcase
		end
	end

endmodule

/* rtl/tbss_merge.sv */
`timescale 1ns / 1ps
module tbss_merge (
	input  logic                                 clk,
	input  tbss_pkg::lane_ctrl_t                 ctrl,
	input  logic [tbss_pkg::GAIN_W-1:0]          output_level,
	input  logic signed [tbss_pkg::SAMPLE_W-1:0] band_y [2][3],
	output logic signed [tbss_pkg::SAMPLE_W-1:0] mix_y [2]
);
	import tbss_pkg::*;

	logic signed [25:0] sum [2];
	logic [25:0]        sum_mag [2];
	logic [41:0]        prod [2];
	logic [29:0]        rnd [2];
	logic signed [30:0] val [2];

	// Sum three bands per lane, apply output level
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			sum[c] = 26'(band_y[c][0]) + 26'(band_y[c][1]) + 26'(band_y[c][2]);
			sum_mag[c] = sum[c][25] ? 26'(-sum[c]) : 26'(sum[c]);
			prod[c] = 42'(output_level) * 42'(sum_mag[c]);
			rnd[c] = 30'((prod[c] + 42'd2048) >> 12);
			val[c] = sum[c][25] ? -$signed({1'b0, rnd[c]}) : $signed({1'b0, rnd[c]});
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mix) begin
			for (int c = 0; c < 2; c++) begin
				mix_y[c] <= sat_sample(40'(val[c]));
			end
		end
	end

endmodule

/* rtl/three_band_svf_saturator.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   tbss_pkg::in_item_t
// result    out        result_valid / result_ready   tbss_pkg::out_item_t
// cfg       in         cfg_we                        cfg_index, cfg_wdata
//
// A stereo frame is accepted only while the sequencer is idle; the next
// frame is not taken until the 12-step sequencer has walked
// both lanes through the filter, the five-stage band pipeline and the mix.
// Reset clears the filter state, the sequencer and result_valid, and loads
// the register reset values. A stalled result holds in the output register;
// the sequencer waits only if a finished frame meets a still-full register.
module three_band_svf_saturator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  tbss_pkg::in_item_t                 sample,
	output logic                               result_valid,
	input  logic                               result_ready,
	output tbss_pkg::out_item_t                result,
	input  logic                               cfg_we,
	input  logic [tbss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import tbss_pkg::*;

	// Configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq_coef    <= 17'd18643;
			cfg_q.damping      <= 16'd32768;
			cfg_q.input_gain   <= 16'd4096;
			cfg_q.output_level <= 16'd4096;
			cfg_q.band[0]      <= 48'h1000_8000_1000;
			cfg_q.band[1]      <= 48'h1000_8000_1000;
			cfg_q.band[2]      <= 48'h1000_8000_1000;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FREQ_COEF:    cfg_q.freq_coef    <= cfg_wdata[COEF_W-1:0];
				REG_DAMPING:      cfg_q.damping      <= cfg_wdata[GAIN_W-1:0];
				REG_INPUT_GAIN:   cfg_q.input_gain   <= cfg_wdata[GAIN_W-1:0];
				REG_OUTPUT_LEVEL: cfg_q.output_level <= cfg_wdata[GAIN_W-1:0];
				REG_LOW_SETTING:  cfg_q.band[0]      <= cfg_wdata[SETTING_W-1:0];
				REG_MID_SETTING:  cfg_q.band[1]      <= cfg_wdata[SETTING_W-1:0];
				REG_TOP_SETTING:  cfg_q.band[2]      <= cfg_wdata[SETTING_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	seq_state_t  state_q;
	seq_state_t  state_d;
	logic [3:0]  cnt_q;
	logic [3:0]  cnt_d;
	logic        out_free;
	logic        load;
	lane_ctrl_t  ctrl;
	in_item_t    sample_q;
	logic        result_valid_q;

	assign out_free = !result_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			SEQ_IDLE: begin
				if (sample_valid) begin
					state_d = SEQ_RUN;
					cnt_d   = STEP_LO;
				end
			end
			SEQ_RUN: begin
				if (cnt_q == STEP_LAST) begin
					state_d = out_free ? SEQ_IDLE : SEQ_WAIT;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			SEQ_WAIT: begin
				if (out_free) state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		sample_ready  = (state_q == SEQ_IDLE);
		ctrl          = '0;
		ctrl.band_sel = 2'(cnt_q - STEP_FEED);
		ctrl.cap_sel  = 2'(cnt_q - STEP_CAP);
		load          = 1'b0;
		if (state_q == SEQ_RUN) begin
			ctrl.svf_lo   = (cnt_q == STEP_LO);
			ctrl.svf_hi   = (cnt_q == STEP_HI);
			ctrl.svf_bp   = (cnt_q == STEP_BP);
			ctrl.band_cap = cnt_q inside {[STEP_CAP : STEP_CAP + 4'd2]};
			ctrl.mix      = (cnt_q == STEP_MIX);
			load          = (cnt_q == STEP_LAST) && out_free;
		end else if (state_q == SEQ_WAIT) begin
			load = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) sample_q <= sample;
	end

	// Lanes, one per channel
	logic signed [SAMPLE_W-1:0] band_y [2][3];
	logic signed [SAMPLE_W-1:0] mix_y [2];

	tbss_lane u_lane_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.right_chan (1'b0),
		.sample     (sample_q.left_sample),
		.low_y      (band_y[0][0]),
		.mid_y      (band_y[0][1]),
		.top_y      (band_y[0][2])
	);

	tbss_lane u_lane_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.right_chan (1'b1),
		.sample     (sample_q.right_sample),
		.low_y      (band_y[1][0]),
		.mid_y      (band_y[1][1]),
		.top_y      (band_y[1][2])
	);

	tbss_merge u_merge (
		.clk          (clk),
		.ctrl         (ctrl),
		.output_level (cfg_q.output_level),
		.band_y       (band_y),
		.mix_y        (mix_y)
	);

	// Output register
	out_item_t result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.left_out  <= mix_y[0];
			result_q.right_out <= mix_y[1];
			result_q.left_low  <= band_y[0][0];
			result_q.left_mid  <= band_y[0][1];
			result_q.left_top  <= band_y[0][2];
			result_q.right_low <= band_y[1][0];
			result_q.right_mid <= band_y[1][1];
			result_q.right_top <= band_y[1][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/tbss_checker.sv */
`timescale 1ns / 1ps
module tbss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                sample_valid,
	input logic                sample_ready,
	input logic                result_valid,
	input logic                result_ready,
	input tbss_pkg::out_item_t result
);
	import tbss_pkg::*;

	// A stalled result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

	// One frame at a time: ready drops after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("input taken again before frame finished");

	// A new result only comes from a frame in flight
	a_result_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared with no frame in flight");

endmodule

bind three_band_svf_saturator tbss_checker u_tbss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* test/three_band_svf_saturator_tb.sv */
`timescale 1ns / 1ps
module three_band_svf_saturator_tb;
	import tbss_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint SMAX = 64'sd8388607;
	localparam longint SMIN = -64'sd8388608;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_ready;
	in_item_t              sample;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	three_band_svf_saturator dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the registers and the filter state
	longint unsigned coef_q, damp_q, in_gain_q, out_level_q;
	longint unsigned band_q [3];
	longint          lowpass_q [2];
	longint          bandpass_q [2];
	longint unsigned tanh_pts [TANH_DEPTH+1];

	in_item_t  frames_to_send [$];
	out_item_t frames_expected [$];
	int        idle_pct;
	int        stall_pct;
	int        mismatches;
	int        frames_sent;
	int        frames_checked;
	int        cfg_writes;
	longint    cycles;

	// ---------------- fixed-point helpers ----------------
	function automatic longint unsigned round_shift(longint unsigned v, int s);
		if (s == 0) return v;
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	function automatic longint unsigned umul_round(longint unsigned c, longint unsigned v, int s);
		longint unsigned hi;
		longint unsigned lo;
		hi = c * (v >> 24);
		lo = c * (v & 64'hFFFFFF);
		return (hi << (24 - s)) + round_shift(lo, s);
	endfunction

	function automatic longint smul_round(longint unsigned c, longint v, int s);
		longint unsigned m;
		longint unsigned r;
		m = (v < 0) ? longint'(-v) : longint'(v);
		r = umul_round(c, m, s);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// tanh points from the 7/6 Pade form, 31 fraction bits
	function automatic void fill_tanh_points();
		longint unsigned xq, s, a, b, num, q, r, prev;
		prev = 0;
		for (int i = 0; i <= TANH_DEPTH; i++) begin
			xq = (64'(i) << 18) / TANH_DEPTH;
			s = (xq * xq) >> 16;
			a = ((((s + (64'd378 << 16)) * s) >> 16) + (64'd17325 << 16)) * s;
			b = ((((64'd28 * s + (64'd3150 << 16)) * s) >> 16) + (64'd62370 << 16)) * s;
			a = (a >> 16) + (64'd135135 << 16);
			b = (b >> 16) + (64'd135135 << 16);
			num = xq * a;
			q = num / b;
			r = num % b;
			for (int k = 0; k < 15; k++) begin
				r = r << 1;
				q = q << 1;
				if (r >= b) begin
					r = r - b;
					q = q | 64'd1;
				end
			end
			if (q > (64'd1 << 31)) q = 64'd1 << 31;
			if (q < prev) q = prev;
			tanh_pts[i] = q;
			prev = q;
		end
	endfunction

	function automatic longint soft_clip(longint a);
		longint unsigned m, t, pos, idx, fr, d;
		m = (a < 0) ? longint'(-a) : longint'(a);
		if (m >= (64'd1 << 25)) begin
			t = tanh_pts[TANH_DEPTH];
		end else begin
			pos = m * TANH_DEPTH;
			idx = pos >> 25;
			fr = pos & ((64'd1 << 25) - 1);
			if (idx >= TANH_DEPTH) idx = TANH_DEPTH - 1;
			d = tanh_pts[idx + 1] - tanh_pts[idx];
			t = tanh_pts[idx] + ((d * fr) >> 25);
		end
		t = round_shift(t, 31 - FRAC);
		return (a < 0) ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint shape_band(longint unsigned setting, int ch, longint part);
		longint unsigned drv, pan, lvl, factor, gain;
		drv = (setting >> 32) & 64'hFFFF;
		pan = (setting >> 16) & 64'hFFFF;
		lvl = setting & 64'hFFFF;
		factor = (ch == 0) ? 64'd65536 - pan : pan;
		gain = umul_round(drv, factor, 16);
		return clamp(smul_round(lvl, soft_clip(smul_round(gain, part, 12)), 12), SAMPLE_W);
	endfunction

	// One stereo frame through both filter lanes; updates the filter state
	function automatic out_item_t process_frame(in_item_t f);
		out_item_t o;
		longint x, lo, hi, bp, yl, ym, yh, y;
		for (int ch = 0; ch < 2; ch++) begin
			x = (ch == 0) ? longint'(f.left_sample) : longint'(f.right_sample);
			lo = clamp(lowpass_q[ch] + smul_round(coef_q, bandpass_q[ch], 16), STATE_W);
			hi = clamp(smul_round(in_gain_q, x, 12) - lo
				- smul_round(damp_q, bandpass_q[ch], 16), STATE_W);
			bp = clamp(bandpass_q[ch] + smul_round(coef_q, hi, 16), STATE_W);
			lowpass_q[ch] = lo;
			bandpass_q[ch] = bp;
			yl = shape_band(band_q[0], ch, lo);
			ym = shape_band(band_q[1], ch, bp);
			yh = shape_band(band_q[2], ch, hi);
			y = clamp(smul_round(out_level_q, yl + ym + yh, 12), SAMPLE_W);
			if (ch == 0) begin
				o.left_out = y[SAMPLE_W-1:0];
				o.left_low = yl[SAMPLE_W-1:0];
				o.left_mid = ym[SAMPLE_W-1:0];
				o.left_top = yh[SAMPLE_W-1:0];
			end else begin
				o.right_out = y[SAMPLE_W-1:0];
				o.right_low = yl[SAMPLE_W-1:0];
				o.right_mid = ym[SAMPLE_W-1:0];
				o.right_top = yh[SAMPLE_W-1:0];
			end
		end
		return o;
	endfunction

	// ---------------- clock, reset, watchdog ----------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver stalls at random
	always @(posedge clk) begin
		result_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Sample driver: predicts each frame on its transaction, then offers the next
	always @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			frames_expected.push_back(process_frame(sample));
			frames_sent <= frames_sent + 1;
		end
		if (!(sample_valid && !sample_ready)) begin
			if (arst_n && frames_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
				sample <= frames_to_send.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		out_item_t want;
		string names [8];
		names = '{"right_top", "right_mid", "right_low", "left_top",
			"left_mid", "left_low", "right_out", "left_out"};
		if (arst_n && result_valid && result_ready) begin
			if (frames_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result transaction with no frame pending: %h", result);
			end else begin
				want = frames_expected.pop_front();
				frames_checked++;
				for (int i = 0; i < 8; i++) begin
					if (result[i*SAMPLE_W +: SAMPLE_W] !== want[i*SAMPLE_W +: SAMPLE_W]) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("frame %0d %s: expected %0d got %0d", frames_checked,
								names[i], $signed(want[i*SAMPLE_W +: SAMPLE_W]),
								$signed(result[i*SAMPLE_W +: SAMPLE_W]));
					end
				end
			end
		end
	end

	// ---------------- shared tasks ----------------
	task automatic send_frame(longint l, longint r);
		in_item_t f;
		f.left_sample = l[SAMPLE_W-1:0];
		f.right_sample = r[SAMPLE_W-1:0];
		frames_to_send.push_back(f);
		wait (frames_to_send.size() < 4);
	endtask

	// Wait until every frame is through and the pipeline has gone quiet
	task automatic drain();
		do @(posedge clk);
		while (frames_to_send.size() > 0 || sample_valid || frames_expected.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_FREQ_COEF:    coef_q = val & 64'h1FFFF;
			REG_DAMPING:      damp_q = val & 64'hFFFF;
			REG_INPUT_GAIN:   in_gain_q = val & 64'hFFFF;
			REG_OUTPUT_LEVEL: out_level_q = val & 64'hFFFF;
			REG_LOW_SETTING:  band_q[0] = val & 64'hFFFF_FFFF_FFFF;
			REG_MID_SETTING:  band_q[1] = val & 64'hFFFF_FFFF_FFFF;
			REG_TOP_SETTING:  band_q[2] = val & 64'hFFFF_FFFF_FFFF;
			default: ;
		endcase
	endtask

	function automatic longint unsigned pick_gain();
		case ($urandom_range(5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(65535);
			default: return $urandom_range(8192);
		endcase
	endfunction

	function automatic longint unsigned pick_band();
		longint unsigned p;
		case ($urandom_range(3))
			0: p = 0;
			1: p = 16'hFFFF;
			default: p = $urandom_range(65535);
		endcase
		return (pick_gain() << 32) | (p << 16) | pick_gain();
	endfunction

	function automatic longint pick_sample();
		case ($urandom_range(7))
			0: return SMAX;
			1: return SMIN;
			2, 3: return longint'($signed(24'($urandom))) >>> $urandom_range(12);
			default: return longint'($signed(24'($urandom)));
		endcase
	endfunction

	// ---------------- tests ----------------
	task automatic test_power_on_values();
		send_frame(0, 0);
		send_frame(SMAX, SMIN);
		send_frame(SMIN, SMAX);
		send_frame(1, -1);
		send_frame(4194304, -4194304);
		drain();
	endtask

	task automatic test_sample_extremes();
		// strong DC drives the filter state into saturation
		write_reg(REG_INPUT_GAIN, 16'hFFFF);
		write_reg(REG_FREQ_COEF, 17'h1FFFF);
		write_reg(REG_DAMPING, 0);
		for (int i = 0; i < 6; i++) send_frame(SMAX, SMIN);
		for (int i = 0; i < 3; i++) send_frame(SMIN, SMAX);
		drain();
		// unused register index must be ignored
		write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_FREQ_COEF, 0);
		write_reg(REG_DAMPING, 16'hFFFF);
		send_frame(SMAX, -1);
		send_frame(0, SMIN);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_FREQ_COEF, 18643);
		write_reg(REG_INPUT_GAIN, 4096);
		write_reg(REG_OUTPUT_LEVEL, 16'hFFFF);
		write_reg(REG_LOW_SETTING, 48'hFFFF_0000_FFFF);
		write_reg(REG_MID_SETTING, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_TOP_SETTING, 48'h0000_8000_0000);
		send_frame(SMAX, SMAX);
		send_frame(-100000, 100000);
		send_frame(SMIN, 0);
		drain();
		write_reg(REG_OUTPUT_LEVEL, 0);
		write_reg(REG_LOW_SETTING, 0);
		write_reg(REG_TOP_SETTING, 48'h4000_FFFF_2000);
		send_frame(2000000, -2000000);
		send_frame(SMAX, SMIN);
		drain();
	endtask

	task automatic test_random_traffic(int phases, int frames_per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(REG_FREQ_COEF, ($urandom_range(3) == 0) ? $urandom_range(131071)
				: $urandom_range(30000));
			write_reg(REG_DAMPING, $urandom_range(65535));
			write_reg(REG_INPUT_GAIN, pick_gain());
			write_reg(REG_OUTPUT_LEVEL, pick_gain());
			write_reg(REG_LOW_SETTING, pick_band());
			write_reg(REG_MID_SETTING, pick_band());
			write_reg(REG_TOP_SETTING, pick_band());
			for (int i = 0; i < frames_per_phase; i++) send_frame(pick_sample(), pick_sample());
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_pct = 23;
		stall_pct = 73;
		mismatches = 0;
		frames_sent = 0;
		frames_checked = 0;
		cfg_writes = 0;
		cycles = 0;
		coef_q = 18643;
		damp_q = 32768;
		in_gain_q = 4096;
		out_level_q = 4096;
		for (int b = 0; b < 3; b++) band_q[b] = 64'd17594333532160;
		for (int c = 0; c < 2; c++) begin
			lowpass_q[c] = 0;
			bandpass_q[c] = 0;
		end
		fill_tanh_points();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_values();
		test_sample_extremes();
		test_register_extremes();
		test_random_traffic(2, 170);
		idle_pct = 73;
		stall_pct = 23;
		test_random_traffic(2, 170);
		idle_pct = 0;
		stall_pct = 0;
		test_random_traffic(2, 170);

		$display("Covered %0d frames, %0d register writes, three idling patterns.",
			frames_sent, cfg_writes);
		$display("Checked %0d results, %0d field mismatches.", frames_checked, mismatches);
		if (mismatches == 0 && frames_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/tbss_pkg.sv
rtl/tbss_lane.sv
rtl/tbss_merge.sv
rtl/three_band_svf_saturator.sv
rtl/tbss_checker.sv
test/three_band_svf_saturator_tb.sv
